/* hdl/single_server_queue_stats_assert.svh */
// Assertion macros used by the checker file of the queue statistics block.
`ifndef SINGLE_SERVER_QUEUE_STATS_ASSERT_SVH
`define SINGLE_SERVER_QUEUE_STATS_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SSQS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SSQS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/ssqs_pkg.sv */
`default_nettype none

package ssqs_pkg;

  localparam int IN_TIME_W     = 24;
  localparam int OUT_TIME_W    = 40;
  localparam int CNT_W         = 32;
  localparam int SUM_W         = 48;
  localparam int FRACTION_BITS = 8;

  localparam logic [63:0] PROBE_RESET_FULL = 64'(400) << FRACTION_BITS;
  localparam logic [OUT_TIME_W-1:0] PROBE_RESET = PROBE_RESET_FULL[OUT_TIME_W-1:0];

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // First field sits in the highest bits.
  typedef struct packed {
    logic [IN_TIME_W-1:0] service_time;
    logic [IN_TIME_W-1:0] interarrival_time;
  } job_t;

  typedef struct packed {
    logic [SUM_W-1:0]      total_service;
    logic [SUM_W-1:0]      total_wait;
    logic [SUM_W-1:0]      total_delay;
    logic [CNT_W-1:0]      present_at_probe;
    logic [CNT_W-1:0]      delayed_jobs;
    logic [OUT_TIME_W-1:0] largest_delay;
    logic [OUT_TIME_W-1:0] departure_out;
    logic [OUT_TIME_W-1:0] node_wait;
    logic [OUT_TIME_W-1:0] queue_delay;
    logic [OUT_TIME_W-1:0] arrival_out;
    logic [CNT_W-1:0]      job_number;
  } result_t;

  localparam int IN_DATA_W  = $bits(job_t);
  localparam int OUT_DATA_W = $bits(result_t);

endpackage

`default_nettype wire

/* hdl/ssqs_in_reg.sv */
`default_nettype none

module ssqs_in_reg import ssqs_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic      in_tready,
  input  wire job_t in_job,
  input  wire logic advance,
  output logic      job_valid,
  output job_t      job
);

  logic valid_r, valid_nxt;
  job_t job_r;

  assign in_tready = !valid_r || advance;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tvalid && in_tready) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      job_r <= in_job;
    end
  end

  assign job_valid = valid_r;
  assign job       = job_r;

endmodule

`default_nettype wire

/* hdl/ssqs_update.sv */
`default_nettype none

module ssqs_update import ssqs_pkg::*; #(
  parameter int TIME_BITS = 40
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_valid,
  input  wire logic [OUT_TIME_W-1:0] cfg_data,
  input  wire logic                  step_en,
  input  wire job_t                  job,
  output result_t                    res
);

  localparam int TW1 = TIME_BITS + 1;
  localparam int CW  = (TIME_BITS > OUT_TIME_W) ? TIME_BITS : OUT_TIME_W;
  localparam int SW1 = ((TIME_BITS > SUM_W) ? TIME_BITS : SUM_W) + 1;
  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

  function automatic logic [CNT_W-1:0] cnt_inc(input logic [CNT_W-1:0] c);
    return (c == CNT_MAX) ? c : c + CNT_W'(1);
  endfunction

  logic [OUT_TIME_W-1:0] probe_time_r;
  logic [TIME_BITS-1:0]  arrival_clock_r, last_departure_r, max_delay_r;
  logic [CNT_W-1:0]      job_cnt_r, delayed_cnt_r, probe_cnt_r;
  logic [SUM_W-1:0]      delay_sum_r, wait_sum_r, service_sum_r;

  logic [TIME_BITS-1:0]  arrival_nxt, departure_nxt, max_delay_nxt;
  logic [CNT_W-1:0]      job_cnt_nxt, delayed_cnt_nxt, probe_cnt_nxt;
  logic [SUM_W-1:0]      delay_sum_nxt, wait_sum_nxt, service_sum_nxt;

  logic [TW1-1:0]        arr_ext, wait_ext, dep_ext;
  logic [TIME_BITS-1:0]  delay, node_wait;
  logic                  late, probe_hit;
  logic [SW1-1:0]        dsum_ext, wsum_ext, ssum_ext;
  logic [CW-1:0]         arr_c, dep_c, probe_c, delay_c, wait_c, max_c;

  always_comb begin
    arr_ext     = TW1'(arrival_clock_r) + TW1'(job.interarrival_time);
    arrival_nxt = arr_ext[TIME_BITS] ? TIME_MAX : arr_ext[TIME_BITS-1:0];

    // Arriving exactly at the last departure is not a delay.
    late  = arrival_nxt < last_departure_r;
    delay = late ? (last_departure_r - arrival_nxt) : '0;

    wait_ext  = TW1'(delay) + TW1'(job.service_time);
    node_wait = wait_ext[TIME_BITS] ? TIME_MAX : wait_ext[TIME_BITS-1:0];

    dep_ext       = TW1'(arrival_nxt) + TW1'(node_wait);
    departure_nxt = dep_ext[TIME_BITS] ? TIME_MAX : dep_ext[TIME_BITS-1:0];

    max_delay_nxt = (delay > max_delay_r) ? delay : max_delay_r;

    arr_c     = CW'(arrival_nxt);
    dep_c     = CW'(departure_nxt);
    probe_c   = CW'(probe_time_r);
    probe_hit = (arr_c <= probe_c) && (dep_c > probe_c);

    job_cnt_nxt     = cnt_inc(job_cnt_r);
    delayed_cnt_nxt = late ? cnt_inc(delayed_cnt_r) : delayed_cnt_r;
    probe_cnt_nxt   = probe_hit ? cnt_inc(probe_cnt_r) : probe_cnt_r;

    dsum_ext = SW1'(delay_sum_r) + SW1'(delay);
    wsum_ext = SW1'(wait_sum_r) + SW1'(node_wait);
    ssum_ext = SW1'(service_sum_r) + SW1'(job.service_time);
    delay_sum_nxt   = (dsum_ext > SW1'(SUM_MAX)) ? SUM_MAX : dsum_ext[SUM_W-1:0];
    wait_sum_nxt    = (wsum_ext > SW1'(SUM_MAX)) ? SUM_MAX : wsum_ext[SUM_W-1:0];
    service_sum_nxt = (ssum_ext > SW1'(SUM_MAX)) ? SUM_MAX : ssum_ext[SUM_W-1:0];

    delay_c = CW'(delay);
    wait_c  = CW'(node_wait);
    max_c   = CW'(max_delay_nxt);

    res.job_number       = job_cnt_nxt;
    res.arrival_out      = arr_c[OUT_TIME_W-1:0];
    res.queue_delay      = delay_c[OUT_TIME_W-1:0];
    res.node_wait        = wait_c[OUT_TIME_W-1:0];
    res.departure_out    = dep_c[OUT_TIME_W-1:0];
    res.largest_delay    = max_c[OUT_TIME_W-1:0];
    res.delayed_jobs     = delayed_cnt_nxt;
    res.present_at_probe = probe_cnt_nxt;
    res.total_delay      = delay_sum_nxt;
    res.total_wait       = wait_sum_nxt;
    res.total_service    = service_sum_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_time_r <= PROBE_RESET;
    end else if (cfg_valid) begin
      probe_time_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arrival_clock_r  <= '0;
      last_departure_r <= '0;
      max_delay_r      <= '0;
      job_cnt_r        <= '0;
      delayed_cnt_r    <= '0;
      probe_cnt_r      <= '0;
      delay_sum_r      <= '0;
      wait_sum_r       <= '0;
      service_sum_r    <= '0;
    end else if (step_en) begin
      arrival_clock_r  <= arrival_nxt;
      last_departure_r <= departure_nxt;
      max_delay_r      <= max_delay_nxt;
      job_cnt_r        <= job_cnt_nxt;
      delayed_cnt_r    <= delayed_cnt_nxt;
      probe_cnt_r      <= probe_cnt_nxt;
      delay_sum_r      <= delay_sum_nxt;
      wait_sum_r       <= wait_sum_nxt;
      service_sum_r    <= service_sum_nxt;
    end
  end

endmodule

`default_nettype wire

/* hdl/ssqs_out_reg.sv */
`default_nettype none

module ssqs_out_reg import ssqs_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    load,
  input  wire result_t res,
  output logic         can_load,
  output logic         out_tvalid,
  input  wire logic    out_tready,
  output result_t      out_res
);

  logic    valid_r, valid_nxt;
  result_t res_r;

  // Refill in the same cycle the held result is taken.
  assign can_load = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_res    = res_r;

endmodule

`default_nettype wire

/* hdl/single_server_queue_stats.sv */
// Channel | Direction | Handshake              | Payload
// in_     | slave     | in_tvalid / in_tready   | in_tdata: interarrival_time, service_time
// out_    | master    | out_tvalid / out_tready | out_tdata: one result record per job
// cfg_    | slave     | cfg_valid / cfg_ready   | cfg_data: probe_time
//
// One job per clock while out_tready is high; out_tvalid comes from the result register.
// The whole Lindley update (arrival, delay, wait, departure, stats) is combinational
// logic between the input register and the result register.
// rst_n is synchronous: clears all statistics, probe_time returns to 400.0.
// A stalled output holds its record and the input register keeps one job.
`default_nettype none

module single_server_queue_stats import ssqs_pkg::*; #(
  parameter int TIME_BITS = 40
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // [23:0] interarrival_time, [47:24] service_time
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // [31:0] job_number, [71:32] arrival_out, [111:72] queue_delay,
  // [151:112] node_wait, [191:152] departure_out, [231:192] largest_delay,
  // [263:232] delayed_jobs, [295:264] present_at_probe, [343:296] total_delay,
  // [391:344] total_wait, [439:392] total_service
  output logic [OUT_DATA_W-1:0]      out_tdata,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [OUT_TIME_W-1:0] cfg_data
);

  job_t    in_job, job;
  logic    job_valid, can_load, advance;
  result_t res, out_res;

  assign in_job    = job_t'(in_tdata);
  assign cfg_ready = 1'b1;
  assign advance   = job_valid && can_load;
  assign out_tdata = out_res;

  ssqs_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_job    (in_job),
    .advance   (advance),
    .job_valid (job_valid),
    .job       (job)
  );

  ssqs_update #(
    .TIME_BITS (TIME_BITS)
  ) u_update (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .step_en   (advance),
    .job       (job),
    .res       (res)
  );

  ssqs_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance),
    .res        (res),
    .can_load   (can_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (out_res)
  );

endmodule

`default_nettype wire

/* hdl/ssqs_chk.sv */
`default_nettype none
`include "single_server_queue_stats_assert.svh"

module ssqs_chk import ssqs_pkg::*; (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata
);

  `SSQS_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed while stalled")
  `SSQS_ASSERT_NOW(a_job_nonzero, out_tvalid, out_tdata[31:0] != 32'd0, "job number is zero")
  `SSQS_ASSERT_NOW(a_wait_ge_delay, out_tvalid, out_tdata[151:112] >= out_tdata[111:72], "wait below delay")
  `SSQS_ASSERT_NOW(a_max_ge_delay, out_tvalid, out_tdata[231:192] >= out_tdata[111:72], "largest delay below delay")
  `SSQS_ASSERT_NOW(a_delayed_le_jobs, out_tvalid, out_tdata[263:232] <= out_tdata[31:0], "more delayed jobs than jobs")

endmodule

bind single_server_queue_stats ssqs_chk u_ssqs_chk (.*);

`default_nettype wire
